/* rtl/sha256_message_digest_defines.svh */
// ----------------------------------------------------------------------------
// SHA-256 message digest: assertion macros
// Shared concurrent assertion forms clocked on clk; SHA_ASSERT is held off during rst.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_DIGEST_DEFINES_SVH
`define SHA256_MESSAGE_DIGEST_DEFINES_SVH

// Assertion clocked on clk, disabled while rst is high.
`define SHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Assertion that also holds while rst is high.
`define SHA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/sha256md_pkg.sv */
// ----------------------------------------------------------------------------
// SHA-256 message digest package
// Word types, round constants, initial hash words and controller codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha256md_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;
  typedef logic [15:0][31:0] block_t;

  // Commands from the message controller to the compression core.
  typedef struct packed {
    logic start;
    logic init;
  } sha256md_cmd_t;

  // Status from the compression core.
  typedef struct packed {
    logic busy;
    logic done;
  } sha256md_stat_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_ADD
  } core_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GO,
    ST_WAIT,
    ST_PAD,
    ST_LEN,
    ST_OUT
  } msg_state_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_PAD,
    KIND_FINAL
  } comp_kind_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

/* rtl/sha256md_round.sv */
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule word, shared by all rounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256md_round (
  input  sha256md_pkg::hash_t  vars,
  input  sha256md_pkg::block_t window,
  input  sha256md_pkg::word_t  round_word,
  input  sha256md_pkg::word_t  round_const,
  output sha256md_pkg::hash_t  vars_next,
  output sha256md_pkg::word_t  sched_word
);
  import sha256md_pkg::*;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  word_t big_s0;
  word_t big_s1;
  word_t choose;
  word_t major;
  word_t t1;
  word_t t2;
  word_t small_s0;
  word_t small_s1;

  // Round sums on the working variables a..h.
  always_comb begin
    big_s1 = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
    big_s0 = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
    choose = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    major = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1 = vars[7] + big_s1 + choose + round_const + round_word;
    t2 = big_s0 + major;
    vars_next[7] = vars[6];
    vars_next[6] = vars[5];
    vars_next[5] = vars[4];
    vars_next[4] = vars[3] + t1;
    vars_next[3] = vars[2];
    vars_next[2] = vars[1];
    vars_next[1] = vars[0];
    vars_next[0] = t1 + t2;
  end

  // Schedule word from the window taps W[r-16], W[r-15], W[r-7] and W[r-2].
  always_comb begin
    small_s0 = rotr(window[1], 7) ^ rotr(window[1], 18) ^ (window[1] >> 3);
    small_s1 = rotr(window[14], 17) ^ rotr(window[14], 19) ^ (window[14] >> 10);
    sched_word = window[0] + small_s0 + window[9] + small_s1;
  end

endmodule

/* rtl/sha256md_core.sv */
// ----------------------------------------------------------------------------
// SHA-256 compression core
// Runs every round through the shared round unit, then folds into the chain value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256md_core (
  input  logic                        clk,
  input  logic                        rst,
  input  sha256md_pkg::sha256md_cmd_t cmd,
  input  sha256md_pkg::block_t        block,
  output sha256md_pkg::sha256md_stat_t stat,
  output sha256md_pkg::hash_t         chain
);
  import sha256md_pkg::*;

  core_state_t cstate;
  core_state_t cstate_next;
  logic [5:0]  rnd;
  hash_t       vars;
  hash_t       vars_rnd;
  block_t      window;
  word_t       sched_word;
  word_t       round_word;

  // The first sixteen rounds rotate the loaded block through the window.
  assign round_word = (rnd[5:4] == 2'b00) ? window[0] : sched_word;

  sha256md_round u_round (
    .vars        (vars),
    .window      (window),
    .round_word  (round_word),
    .round_const (ROUND_K[rnd]),
    .vars_next   (vars_rnd),
    .sched_word  (sched_word)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= CORE_IDLE;
    end else begin
      cstate <= cstate_next;
    end
  end

  // Next state and status.
  always_comb begin
    cstate_next = cstate;
    stat.busy = 1'b0;
    stat.done = 1'b0;
    unique case (cstate)
      CORE_IDLE: begin
        if (cmd.start) begin
          cstate_next = CORE_RUN;
        end
      end
      CORE_RUN: begin
        stat.busy = 1'b1;
        if (rnd == LAST_ROUND) begin
          cstate_next = CORE_ADD;
        end
      end
      CORE_ADD: begin
        stat.busy = 1'b1;
        stat.done = 1'b1;
        cstate_next = CORE_IDLE;
      end
      default: begin
        cstate_next = CORE_IDLE;
      end
    endcase
  end

  // Round counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (cstate == CORE_IDLE) begin
      rnd <= '0;
    end else if (cstate == CORE_RUN) begin
      rnd <= rnd + 6'd1;
    end
  end

  // Working variables and schedule window.
  always_ff @(posedge clk) begin
    if (cstate == CORE_IDLE && cmd.start) begin
      vars <= chain;
      window <= block;
    end else if (cstate == CORE_RUN) begin
      vars <= vars_rnd;
      window <= {round_word, window[15:1]};
    end
  end

  // Chain value: initial words on reset or restart, sum after each block.
  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      for (int k = 0; k < 8; k++) begin
        chain[k] <= INIT_HASH[k];
      end
    end else if (cstate == CORE_ADD) begin
      for (int k = 0; k < 8; k++) begin
        chain[k] <= chain[k] + vars[k];
      end
    end
  end

endmodule

/* rtl/sha256_message_digest.sv */
// SHA-256 digest of a byte stream, one byte per input word.
// The 64th byte of a block starts a compression (64 rounds in the shared
// round unit, one load, one chain add), and no byte is taken until it is done.
// An end word adds a pad step and a compression, or with a second pad block
// a length step and a further compression, then eight digest words. Reset
// restores the initial hash and clears the count.
// ----------------------------------------------------------------------------
// SHA-256 message digest top level
// Gathers bytes into the block buffer, pads, and streams out the digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sha256_message_digest_defines.svh"

module sha256_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  logic [0:0]  s_tuser,   // [0] byte_valid
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [2:0]  m_tuser,   // [2:0] word_number
  output logic        m_tlast    // final_word
);
  import sha256md_pkg::*;

  // Place a byte in its lane and clear the lanes below it.
  function automatic word_t put_byte(input word_t old, input logic [1:0] lane,
                                     input logic [7:0] b);
    case (lane)
      2'd0:    put_byte = {b, 24'd0};
      2'd1:    put_byte = {old[31:24], b, 16'd0};
      2'd2:    put_byte = {old[31:16], b, 8'd0};
      default: put_byte = {old[31:8], b};
    endcase
  endfunction

  msg_state_t     state;
  msg_state_t     state_next;
  comp_kind_t     kind;
  logic           pend_last;
  logic [63:0]    byte_total;
  logic [63:0]    bit_length;
  logic [2:0]     out_idx;
  block_t         block_buffer;
  logic [5:0]     pos;
  logic [3:0]     wi;
  logic           pad_two;
  logic           in_acc;
  logic           out_acc;
  logic           restart_ok;
  sha256md_cmd_t  core_cmd;
  sha256md_stat_t core_stat;
  hash_t          chain;

  assign pos = byte_total[5:0];
  assign wi = pos[5:2];
  assign pad_two = (pos[5:3] == 3'b111);
  assign bit_length = {byte_total[60:0], 3'b000};
  assign in_acc = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;
  assign restart_ok = s_tready && out_idx == 3'd0 && byte_total == 64'd0;

  sha256md_core u_core (
    .clk   (clk),
    .rst   (rst),
    .cmd   (core_cmd),
    .block (block_buffer),
    .stat  (core_stat),
    .chain (chain)
  );

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshakes and core commands.
  always_comb begin
    state_next = state;
    core_cmd = '0;
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (in_acc) begin
          if (s_tuser[0] && pos == LAST_POS) begin
            state_next = ST_GO;
          end else if (s_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_GO: begin
        core_cmd.start = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (core_stat.done) begin
          unique case (kind)
            KIND_DATA:  state_next = pend_last ? ST_PAD : ST_IDLE;
            KIND_PAD:   state_next = ST_LEN;
            KIND_FINAL: state_next = ST_OUT;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_PAD: begin
        state_next = ST_GO;
      end
      ST_LEN: begin
        state_next = ST_GO;
      end
      ST_OUT: begin
        m_tvalid = 1'b1;
        if (out_acc && out_idx == LAST_WORD) begin
          core_cmd.init = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Byte count, compression kind and output word index.
  always_ff @(posedge clk) begin
    if (rst) begin
      kind <= KIND_DATA;
      pend_last <= 1'b0;
      byte_total <= '0;
      out_idx <= '0;
    end else begin
      if (state == ST_IDLE && in_acc) begin
        kind <= KIND_DATA;
        pend_last <= s_tlast;
        if (s_tuser[0]) begin
          byte_total <= byte_total + 64'd1;
        end
      end
      if (state == ST_PAD) begin
        kind <= pad_two ? KIND_PAD : KIND_FINAL;
      end
      if (state == ST_LEN) begin
        kind <= KIND_FINAL;
      end
      if (out_acc) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == LAST_WORD) begin
          byte_total <= '0;
        end
      end
    end
  end

  // Block buffer: byte writes, padding and the length words.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc && s_tuser[0]) begin
      block_buffer[wi] <= put_byte(block_buffer[wi], pos[1:0], s_tdata);
    end else if (state == ST_PAD) begin
      // The length words go in right away when they fit behind the pad byte.
      for (int k = 0; k < 16; k++) begin
        if (!pad_two && k == 14) begin
          block_buffer[k] <= bit_length[63:32];
        end else if (!pad_two && k == 15) begin
          block_buffer[k] <= bit_length[31:0];
        end else if (4'(k) > wi) begin
          block_buffer[k] <= '0;
        end
      end
      block_buffer[wi] <= put_byte(block_buffer[wi], pos[1:0], PAD_BYTE);
    end else if (state == ST_LEN) begin
      for (int k = 0; k < 14; k++) begin
        block_buffer[k] <= '0;
      end
      block_buffer[14] <= bit_length[63:32];
      block_buffer[15] <= bit_length[31:0];
    end
  end

  // Digest words come straight from the chain value.
  assign m_tdata = chain[out_idx];
  assign m_tuser = out_idx;
  assign m_tlast = (out_idx == LAST_WORD);

  // Checks on the sequencing between controller and core.
  `SHA_ASSERT_ALWAYS(a_no_overlap, !(s_tready && m_tvalid), "input taken during digest output")
  `SHA_ASSERT(a_core_waited, core_stat.busy |-> (state == ST_WAIT), "core busy outside wait")
  `SHA_ASSERT(a_back_to_idle, (out_acc && m_tlast) |=> restart_ok, "no clean restart after digest")

endmodule
